/* rtl/core/job_table_id_allocator_macros.svh */
// Assertion macros for the job table ID allocator.
// Used by files that carry concurrent checks; empty when SYNTH is set.
`ifndef JOB_TABLE_ID_ALLOCATOR_MACROS_SVH
`define JOB_TABLE_ID_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define JTA_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jta check failed");
`define JTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jta check failed");
`else
`define JTA_ASSERT_IMPL(label, ante, cons)
`define JTA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/jta_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the job table ID allocator.
// No dependencies; used by every module of the block.
package jta_pkg;

   localparam int FUNC_W       = 3;
   localparam int KEY_W        = 22;
   localparam int JOB_W        = 8;
   localparam int STAT_W       = 32;
   localparam int CNT_W        = 9;
   localparam int RC_W         = 2;
   localparam int DEF_MAX_JOBS = 16;

   typedef enum logic [FUNC_W-1:0] {
      FN_ADD        = 3'd0,
      FN_JID_BY_KEY = 3'd1,
      FN_KEY_BY_JID = 3'd2,
      FN_REMOVE_KEY = 3'd3,
      FN_REMOVE_JID = 3'd4,
      FN_SET_STATUS = 3'd5,
      FN_GET_STATUS = 3'd6,
      FN_CLEAR      = 3'd7
   } func_type;

   typedef enum logic [RC_W-1:0] {
      RC_OK        = 2'd0,
      RC_NOT_FOUND = 2'd1,
      RC_DUPLICATE = 2'd2,
      RC_FULL      = 2'd3
   } rc_type;

   // sequencer to compare unit
   typedef struct packed {
      logic start;
      logic cmp_en;
   } scan_ctl_type;

   // compare unit to sequencer
   typedef struct packed {
      logic hit;
      logic has_free;
   } scan_res_type;

   // slot memory write request
   typedef struct packed {
      logic              key_we;
      logic              status_we;
      logic [KEY_W-1:0]  key;
      logic [STAT_W-1:0] status;
   } mem_wr_type;

endpackage

/* rtl/core/jta_slot_mem.sv */
`timescale 1ns / 1ps
// Key and status storage for the job slots, one write and one read port.
// Depends on jta_pkg.
module jta_slot_mem #(
   parameter int MAX_JOBS = jta_pkg::DEF_MAX_JOBS,
   localparam int JW = $clog2(MAX_JOBS)
) (
   input  logic                       clock,
   input  jta_pkg::mem_wr_type        wr,
   input  logic [JW-1:0]              wr_addr,
   input  logic [JW-1:0]              rd_addr,
   output logic [jta_pkg::KEY_W-1:0]  rd_key,
   output logic [jta_pkg::STAT_W-1:0] rd_status
);

   logic [jta_pkg::KEY_W-1:0]  key_mem_ff    [MAX_JOBS];
   logic [jta_pkg::STAT_W-1:0] status_mem_ff [MAX_JOBS];
   logic [jta_pkg::KEY_W-1:0]  rd_key_ff;
   logic [jta_pkg::STAT_W-1:0] rd_status_ff;

   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem_ff[wr_addr] <= wr.key;
      end
      rd_key_ff <= key_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.status_we) begin
         status_mem_ff[wr_addr] <= wr.status;
      end
      rd_status_ff <= status_mem_ff[rd_addr];
   end

   assign rd_key    = rd_key_ff;
   assign rd_status = rd_status_ff;

endmodule

/* rtl/core/jta_scan_unit.sv */
`timescale 1ns / 1ps
// Shared key compare unit: visits one slot per cycle, keeps the first
// matching slot and the lowest free slot. Depends on jta_pkg.
module jta_scan_unit #(
   parameter int MAX_JOBS = jta_pkg::DEF_MAX_JOBS,
   localparam int JW = $clog2(MAX_JOBS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  jta_pkg::scan_ctl_type     ctl,
   input  logic [JW-1:0]             cmp_idx,
   input  logic                      slot_valid,
   input  logic [jta_pkg::KEY_W-1:0] rd_key,
   input  logic [jta_pkg::KEY_W-1:0] req_key,
   output jta_pkg::scan_res_type     res,
   output logic [JW-1:0]             hit_idx,
   output logic [JW-1:0]             free_idx
);

   logic          hit_ff, hit_in;
   logic          free_ff, free_in;
   logic [JW-1:0] hit_idx_ff, hit_idx_in;
   logic [JW-1:0] free_idx_ff, free_idx_in;
   logic          match;

   assign match = slot_valid && (rd_key == req_key);

   always_comb begin
      hit_in      = hit_ff;
      free_in     = free_ff;
      hit_idx_in  = hit_idx_ff;
      free_idx_in = free_idx_ff;
      if (ctl.start) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (ctl.cmp_en) begin
         // first hit / first hole wins, later ones are ignored
         if (match && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx;
         end
         if (!slot_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign res.hit      = hit_ff;
   assign res.has_free = free_ff;
   assign hit_idx      = hit_idx_ff;
   assign free_idx     = free_idx_ff;

endmodule

/* rtl/core/job_table_id_allocator.sv */
`timescale 1ns / 1ps
// Job table with lowest-free ID allocation and lookup by key.
// Add, lookup by key and remove by key sweep all slots through one key
// compare unit, one slot per cycle off the key memory read port. A new
// request is taken only once the last result is loaded into the output register.
// Lookup/get by job number wait for the memory read; other requests go straight to done.
// Reset clears valid marks, count and handshakes; key/status memory is not swept.
module job_table_id_allocator #(
   parameter int MAX_JOBS = jta_pkg::DEF_MAX_JOBS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,  // group_key, job_number, status_value, pad
   input  logic [jta_pkg::FUNC_W-1:0]  req_tuser,  // func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [71:0]                 rsp_tdata,  // job_out, key_out, status_out, entry_count, pad
   output logic [jta_pkg::RC_W-1:0]    rsp_tuser   // result_code
);

   localparam int JW = $clog2(MAX_JOBS);
   localparam int CW = $clog2(MAX_JOBS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic                        req_acc;
   logic [jta_pkg::KEY_W-1:0]   req_key_ff;
   logic [jta_pkg::JOB_W-1:0]   req_job_ff;
   logic [jta_pkg::STAT_W-1:0]  req_stat_ff;
   jta_pkg::func_type           req_func_ff;

   logic [MAX_JOBS-1:0]         slot_valid_ff, slot_valid_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [JW-1:0]               issue_idx_ff;
   logic                        cmp_en_ff;
   logic [JW-1:0]               cmp_idx_ff;

   jta_pkg::scan_ctl_type       scan_ctl;
   jta_pkg::scan_res_type       scan_res;
   logic [JW-1:0]               hit_idx, free_idx;
   logic [jta_pkg::KEY_W-1:0]   rd_key;
   logic [jta_pkg::STAT_W-1:0]  rd_status;
   logic [JW-1:0]               rd_addr;
   jta_pkg::mem_wr_type         wr_req, wr_mem;
   logic [JW-1:0]               wr_addr;

   logic                        out_free, commit, key_op;
   logic [JW-1:0]               jn_idx;
   logic                        jn_in_range, job_held;

   jta_pkg::rc_type             rc_in;
   logic [jta_pkg::JOB_W-1:0]   job_in;
   logic [jta_pkg::KEY_W-1:0]   kout_in;
   logic [jta_pkg::STAT_W-1:0]  sout_in;

   logic                        rsp_valid_ff;
   jta_pkg::rc_type             rsp_rc_ff;
   logic [jta_pkg::JOB_W-1:0]   rsp_job_ff;
   logic [jta_pkg::KEY_W-1:0]   rsp_key_ff;
   logic [jta_pkg::STAT_W-1:0]  rsp_stat_ff;
   logic [jta_pkg::CNT_W-1:0]   rsp_cnt_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;

   assign key_op = (req_tuser == jta_pkg::FN_ADD) || (req_tuser == jta_pkg::FN_JID_BY_KEY) ||
                   (req_tuser == jta_pkg::FN_REMOVE_KEY);

   assign jn_idx      = req_job_ff[JW-1:0];
   assign jn_in_range = ({1'b0, req_job_ff} < (jta_pkg::JOB_W+1)'(MAX_JOBS));
   assign job_held    = jn_in_range && slot_valid_ff[jn_idx];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (key_op) begin
                  state_in = ST_SCAN;
               end else if ((req_tuser == jta_pkg::FN_KEY_BY_JID) ||
                            (req_tuser == jta_pkg::FN_GET_STATUS)) begin
                  state_in = ST_WAIT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (issue_idx_ff == JW'(MAX_JOBS - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_en_ff    <= 1'b0;
         issue_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cmp_en_ff <= (state_ff == ST_SCAN);
         if (req_acc) begin
            issue_idx_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            issue_idx_ff <= issue_idx_ff + 1'b1;
         end
      end
      cmp_idx_ff <= issue_idx_ff;
      if (req_acc) begin
         req_func_ff <= jta_pkg::func_type'(req_tuser);
         req_key_ff  <= req_tdata[21:0];
         req_job_ff  <= req_tdata[29:22];
         req_stat_ff <= req_tdata[61:30];
      end
   end

   assign scan_ctl.start  = req_acc;
   assign scan_ctl.cmp_en = cmp_en_ff;
   assign rd_addr = (state_ff == ST_SCAN) ? issue_idx_ff : jn_idx;

   jta_scan_unit #(.MAX_JOBS(MAX_JOBS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .cmp_idx    (cmp_idx_ff),
      .slot_valid (slot_valid_ff[cmp_idx_ff]),
      .rd_key     (rd_key),
      .req_key    (req_key_ff),
      .res        (scan_res),
      .hit_idx    (hit_idx),
      .free_idx   (free_idx)
   );

   jta_slot_mem #(.MAX_JOBS(MAX_JOBS)) u_mem (
      .clock     (clock),
      .wr        (wr_mem),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_status (rd_status)
   );

   // request outcome, applied in the cycle the result is loaded
   always_comb begin
      rc_in         = jta_pkg::RC_NOT_FOUND;
      job_in        = '0;
      kout_in       = '0;
      sout_in       = '0;
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      wr_req        = '0;
      wr_addr       = jn_idx;
      case (req_func_ff)
         jta_pkg::FN_ADD: begin
            if (scan_res.hit) begin
               rc_in = jta_pkg::RC_DUPLICATE;
            end else if (!scan_res.has_free) begin
               rc_in = jta_pkg::RC_FULL;
            end else begin
               rc_in                   = jta_pkg::RC_OK;
               job_in                  = jta_pkg::JOB_W'(free_idx);
               slot_valid_in[free_idx] = 1'b1;
               count_in                = count_ff + 1'b1;
               wr_req.key_we           = 1'b1;
               wr_req.status_we        = 1'b1;
               wr_req.key              = req_key_ff;
               wr_req.status           = '1;
               wr_addr                 = free_idx;
            end
         end
         jta_pkg::FN_JID_BY_KEY: begin
            if (scan_res.hit) begin
               rc_in  = jta_pkg::RC_OK;
               job_in = jta_pkg::JOB_W'(hit_idx);
            end
         end
         jta_pkg::FN_KEY_BY_JID: begin
            if (job_held) begin
               rc_in   = jta_pkg::RC_OK;
               job_in  = req_job_ff;
               kout_in = rd_key;
            end
         end
         jta_pkg::FN_REMOVE_KEY: begin
            if (scan_res.hit) begin
               rc_in                  = jta_pkg::RC_OK;
               job_in                 = jta_pkg::JOB_W'(hit_idx);
               slot_valid_in[hit_idx] = 1'b0;
               count_in               = count_ff - 1'b1;
            end
         end
         jta_pkg::FN_REMOVE_JID: begin
            if (job_held) begin
               rc_in                 = jta_pkg::RC_OK;
               job_in                = req_job_ff;
               slot_valid_in[jn_idx] = 1'b0;
               count_in              = count_ff - 1'b1;
            end
         end
         jta_pkg::FN_SET_STATUS: begin
            if (job_held) begin
               rc_in            = jta_pkg::RC_OK;
               job_in           = req_job_ff;
               wr_req.status_we = 1'b1;
               wr_req.status    = req_stat_ff;
            end
         end
         jta_pkg::FN_GET_STATUS: begin
            if (job_held) begin
               rc_in   = jta_pkg::RC_OK;
               job_in  = req_job_ff;
               sout_in = rd_status;
            end
         end
         jta_pkg::FN_CLEAR: begin
            rc_in         = jta_pkg::RC_OK;
            slot_valid_in = '0;
            count_in      = '0;
         end
         default: rc_in = jta_pkg::RC_NOT_FOUND;
      endcase
   end

   always_comb begin
      wr_mem           = wr_req;
      wr_mem.key_we    = wr_req.key_we && commit;
      wr_mem.status_we = wr_req.status_we && commit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit) begin
            slot_valid_ff <= slot_valid_in;
            count_ff      <= count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (commit) begin
         rsp_rc_ff   <= rc_in;
         rsp_job_ff  <= job_in;
         rsp_key_ff  <= kout_in;
         rsp_stat_ff <= sout_in;
         rsp_cnt_ff  <= jta_pkg::CNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_rc_ff;
   assign rsp_tdata  = {1'b0, rsp_cnt_ff, rsp_stat_ff, rsp_key_ff, rsp_job_ff};

`include "job_table_id_allocator_macros.svh"

   `JTA_ASSERT_IMPL(a_count_matches_marks, 1'b1, $countones(slot_valid_ff) == int'(count_ff))
   `JTA_ASSERT_IMPL(a_count_bounded, 1'b1, int'(count_ff) <= MAX_JOBS)
   `JTA_ASSERT_NEXT(a_accept_starts_work, req_acc, state_ff != ST_IDLE)
   `JTA_ASSERT_NEXT(a_commit_shows_result, commit, rsp_tvalid)

endmodule
